[sv/brg2d_pkg.sv]
// brg2d_pkg: shared types, constants and helpers for the 2D Burgers stencil block.
// Used by brg2d_cell, brg2d_line_bank, burgers_2d_stencil_step and its testbench.
// No dependencies.
package brg2d_pkg;

  localparam int SAMPLE_BITS = 32;
  localparam int MAX_COLS    = 64;
  localparam int COL_W       = 6;
  localparam int ROW_W       = 12;
  localparam int SUM_W       = 64;
  localparam int PROD_W      = 96;
  localparam int NUM_CELLS   = 4;
  localparam int ADV_SHIFT   = 54;
  localparam int DIF_SHIFT   = 30;

  localparam logic [PROD_W-1:0] TERM_CAP = PROD_W'(1) << 60;
  localparam logic [PROD_W-1:0] RND_ADV  = PROD_W'(1) << (ADV_SHIFT - 1);
  localparam logic [PROD_W-1:0] RND_DIF  = PROD_W'(1) << (DIF_SHIFT - 1);

  localparam logic signed [SUM_W-1:0] SAMP_MAX = SUM_W'(64'sh7FFF_FFFF);
  localparam logic signed [SUM_W-1:0] SAMP_MIN = -SUM_W'(64'sh8000_0000);

  // Grid size limits
  localparam logic [6:0]  COLS_MIN = 7'd3;
  localparam logic [6:0]  COLS_MAX = 7'd64;
  localparam logic [12:0] ROWS_MIN = 13'd3;
  localparam logic [12:0] ROWS_MAX = 13'd4096;

  typedef enum logic [1:0] {
    TERM_ADV_COL,
    TERM_ADV_ROW,
    TERM_DIF_COL,
    TERM_DIF_ROW
  } term_kind_t;

  typedef enum logic [2:0] {
    REG_ADV_COL,
    REG_ADV_ROW,
    REG_DIF_COL,
    REG_DIF_ROW,
    REG_BOUNDARY,
    REG_GRID_COLS,
    REG_GRID_ROWS
  } cfg_reg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD0,
    S_RD1,
    S_RD2,
    S_RD3,
    S_ISSUE_U,
    S_ISSUE_V,
    S_WAIT,
    S_EMIT1,
    S_EMIT2
  } state_t;

  // Five-point neighborhood plus center velocities
  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] cen;
    logic signed [SAMPLE_BITS-1:0] west;
    logic signed [SAMPLE_BITS-1:0] east;
    logic signed [SAMPLE_BITS-1:0] north;
    logic signed [SAMPLE_BITS-1:0] south;
    logic signed [SAMPLE_BITS-1:0] uc;
    logic signed [SAMPLE_BITS-1:0] vc;
  } stencil_t;

  // Word handed from cell to cell: operands and running sum
  typedef struct packed {
    logic                    valid;
    logic                    is_v;
    stencil_t                st;
    logic signed [SUM_W-1:0] sum;
  } chain_word_t;

  function automatic logic signed [33:0] sx34(input logic signed [SAMPLE_BITS-1:0] x);
    return {{2{x[SAMPLE_BITS-1]}}, x};
  endfunction

  function automatic logic signed [SUM_W-1:0] sx64(input logic signed [SAMPLE_BITS-1:0] x);
    return {{(SUM_W-SAMPLE_BITS){x[SAMPLE_BITS-1]}}, x};
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] sat32(input logic signed [SUM_W-1:0] x);
    logic signed [SAMPLE_BITS-1:0] r;
    if (x > SAMP_MAX) r = SAMP_MAX[SAMPLE_BITS-1:0];
    else if (x < SAMP_MIN) r = SAMP_MIN[SAMPLE_BITS-1:0];
    else r = x[SAMPLE_BITS-1:0];
    return r;
  endfunction

endpackage

[sv/brg2d_line_bank.sv]
// brg2d_line_bank: one row of the line store, u and v packed per entry.
// One write port, one registered read port. Depends on brg2d_pkg.
module brg2d_line_bank (
  input  logic                                 clk,
  input  logic                                 wr_en,
  input  logic [brg2d_pkg::COL_W-1:0]          wr_addr,
  input  logic [2*brg2d_pkg::SAMPLE_BITS-1:0]  wr_data,
  input  logic [brg2d_pkg::COL_W-1:0]          rd_addr,
  output logic [2*brg2d_pkg::SAMPLE_BITS-1:0]  rd_data
);

  logic [2*brg2d_pkg::SAMPLE_BITS-1:0] mem [brg2d_pkg::MAX_COLS];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read, old data on a same-address write
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

[sv/brg2d_cell.sv]
// brg2d_cell: one term of the stencil update, five pipeline stages.
// Adds its rounded, signed term to the running sum and hands the word on.
// Depends on brg2d_pkg.
module brg2d_cell (
  input  logic                    clk,
  input  logic                    rst,
  input  brg2d_pkg::term_kind_t   kind,
  input  logic [31:0]             coef,
  input  brg2d_pkg::chain_word_t  din,
  output brg2d_pkg::chain_word_t  dout
);

  logic                    is_diff;
  logic signed [33:0]      op_p;
  logic signed [33:0]      op_q;
  logic [33:0]             mag_p;
  logic [32:0]             mag_q;
  logic [63:0]             prod_pq;
  logic [63:0]             prod_ext;
  logic [63:0]             mul_lo;
  logic [63:0]             mul_hi;
  logic [brg2d_pkg::PROD_W-1:0] shifted;
  logic [60:0]             term_mag;
  logic signed [brg2d_pkg::SUM_W-1:0] term;

  brg2d_pkg::chain_word_t  w1, w2, w3, w4, w5, w5_next;
  logic                    neg1, neg2, neg3, neg4;
  logic [33:0]             mp1;
  logic [32:0]             mq1;
  logic [63:0]             a2;
  logic [63:0]             plo3, phi3;
  logic [brg2d_pkg::PROD_W-1:0] p4;

  assign is_diff = (kind == brg2d_pkg::TERM_DIF_COL) || (kind == brg2d_pkg::TERM_DIF_ROW);

  // operand select: velocity and difference, or laplacian part
  always_comb begin
    op_p = '0;
    op_q = '0;
    case (kind)
      brg2d_pkg::TERM_ADV_COL: begin
        op_p = brg2d_pkg::sx34(din.st.uc);
        op_q = brg2d_pkg::sx34(din.st.cen) - brg2d_pkg::sx34(din.st.west);
      end
      brg2d_pkg::TERM_ADV_ROW: begin
        op_p = brg2d_pkg::sx34(din.st.vc);
        op_q = brg2d_pkg::sx34(din.st.cen) - brg2d_pkg::sx34(din.st.north);
      end
      brg2d_pkg::TERM_DIF_COL: begin
        op_p = brg2d_pkg::sx34(din.st.east) - (brg2d_pkg::sx34(din.st.cen) <<< 1)
             + brg2d_pkg::sx34(din.st.west);
      end
      brg2d_pkg::TERM_DIF_ROW: begin
        op_p = brg2d_pkg::sx34(din.st.south) - (brg2d_pkg::sx34(din.st.cen) <<< 1)
             + brg2d_pkg::sx34(din.st.north);
      end
      default: begin
        op_p = '0;
      end
    endcase
    mag_p = op_p[33] ? 34'(-op_p) : 34'(op_p);
    mag_q = op_q[33] ? 33'(-op_q) : 33'(op_q);
  end

  // |p| * |q|, bypassed for diffusion terms
  always_comb begin
    prod_pq  = mp1[31:0] * mq1[31:0];
    prod_ext = mq1[32] ? {mp1[31:0], 32'b0} : 64'b0;
  end

  // times coefficient, split in two 32-bit halves
  always_comb begin
    mul_lo = a2[31:0] * coef;
    mul_hi = a2[63:32] * coef;
  end

  // shift, cap and apply sign to the running sum
  always_comb begin
    shifted  = is_diff ? (p4 >> brg2d_pkg::DIF_SHIFT) : (p4 >> brg2d_pkg::ADV_SHIFT);
    term_mag = (shifted > brg2d_pkg::TERM_CAP) ? brg2d_pkg::TERM_CAP[60:0] : shifted[60:0];
    term     = {3'b0, term_mag};
  end

  // advection subtracts, diffusion adds; a negative term flips that
  always_comb begin
    w5_next     = w4;
    w5_next.sum = (is_diff ^ neg4) ? (w4.sum + term) : (w4.sum - term);
  end

  // pipeline registers
  always_ff @(posedge clk) begin
    if (rst) begin
      w1.valid <= 1'b0;
      w2.valid <= 1'b0;
      w3.valid <= 1'b0;
      w4.valid <= 1'b0;
      w5.valid <= 1'b0;
    end else begin
      w1   <= din;
      neg1 <= op_p[33] ^ op_q[33];
      mp1  <= mag_p;
      mq1  <= mag_q;

      w2   <= w1;
      neg2 <= neg1;
      a2   <= is_diff ? {30'b0, mp1} : (prod_pq + prod_ext);

      w3   <= w2;
      neg3 <= neg2;
      plo3 <= mul_lo;
      phi3 <= mul_hi;

      w4   <= w3;
      neg4 <= neg3;
      p4   <= {phi3, 32'b0} + {32'b0, plo3} + (is_diff ? brg2d_pkg::RND_DIF : brg2d_pkg::RND_ADV);

      w5   <= w5_next;
    end
  end

  assign dout = w5;

endmodule

[sv/burgers_2d_stencil_step.sv]
// One explicit time step of the 2D viscous Burgers equation, streamed in raster order.
// A grid point is handled whole before the next is accepted: the accept, four line-bank
// reads (one read port per bank), an issue of the u field and then the v field, the chain
// of four term cells (five stages each, u and v fields passing back to back), then one
// result word, with a second on the last row. First-row points give no result and
// return to idle after the reads. Receiver stalls hold the block in its emit states.
// Input at row r gives row r-1 of the result; on the last row it also gives the boundary
// point of row r.
// Depends on brg2d_pkg, brg2d_line_bank, brg2d_cell.
module burgers_2d_stencil_step (
  input  logic        clk,
  input  logic        rst,
  // input words: u_in [31:0], v_in [63:32]
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,
  // result words: u_out [31:0], v_out [63:32], out_row [75:64], out_col [81:76]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [87:0] m_tdata,
  output logic        m_tlast,   // last_of_run
  output logic        m_tuser,   // frame_done
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int SB = brg2d_pkg::SAMPLE_BITS;

  brg2d_pkg::state_t state, state_next;

  logic [31:0] coef_adv_col, coef_adv_row, coef_diff_col, coef_diff_row;
  logic [31:0] boundary_value;
  logic [6:0]  grid_cols;
  logic [12:0] grid_rows;

  logic [brg2d_pkg::ROW_W-1:0] row_count;
  logic [brg2d_pkg::COL_W-1:0] col_count;

  logic [SB-1:0]               in_u, in_v;
  logic [brg2d_pkg::ROW_W-1:0] pos_r;
  logic [brg2d_pkg::COL_W-1:0] pos_c;
  logic                        has_res1, has_res2, edge1, done2;

  logic [2*SB-1:0] st_west, st_north, st_cen, st_east;
  logic [SB-1:0]   res_u, res_v;

  logic [6:0]  cols_eff;
  logic [12:0] rows_eff;
  logic        last_col, last_row, edge_now, s_acc, cfg_wr;
  logic [brg2d_pkg::ROW_W-1:0] prow;

  logic [brg2d_pkg::COL_W-1:0] prv_addr, rd_addr0, rd_addr1;
  logic [2*SB-1:0]             rd_data0, rd_data1, prv_rd, cur_rd;

  brg2d_pkg::chain_word_t chain [brg2d_pkg::NUM_CELLS+1];
  logic [31:0]            cell_coef [brg2d_pkg::NUM_CELLS];
  logic                   emit2;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_adv_col   <= 32'd4831838;
      coef_adv_row   <= 32'd4831838;
      coef_diff_col  <= 32'd966368;
      coef_diff_row  <= 32'd966368;
      boundary_value <= 32'd16777216;
      grid_cols      <= 7'd41;
      grid_rows      <= 13'd41;
    end else if (cfg_wr) begin
      case (brg2d_pkg::cfg_reg_t'(paddr[4:2]))
        brg2d_pkg::REG_ADV_COL:   coef_adv_col   <= pwdata;
        brg2d_pkg::REG_ADV_ROW:   coef_adv_row   <= pwdata;
        brg2d_pkg::REG_DIF_COL:   coef_diff_col  <= pwdata;
        brg2d_pkg::REG_DIF_ROW:   coef_diff_row  <= pwdata;
        brg2d_pkg::REG_BOUNDARY:  boundary_value <= pwdata;
        brg2d_pkg::REG_GRID_COLS: grid_cols      <= pwdata[6:0];
        brg2d_pkg::REG_GRID_ROWS: grid_rows      <= pwdata[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (brg2d_pkg::cfg_reg_t'(paddr[4:2]))
      brg2d_pkg::REG_ADV_COL:   prdata = coef_adv_col;
      brg2d_pkg::REG_ADV_ROW:   prdata = coef_adv_row;
      brg2d_pkg::REG_DIF_COL:   prdata = coef_diff_col;
      brg2d_pkg::REG_DIF_ROW:   prdata = coef_diff_row;
      brg2d_pkg::REG_BOUNDARY:  prdata = boundary_value;
      brg2d_pkg::REG_GRID_COLS: prdata = {25'b0, grid_cols};
      brg2d_pkg::REG_GRID_ROWS: prdata = {19'b0, grid_rows};
      default:                  prdata = 32'b0;
    endcase
  end

  // position decode for the word being accepted
  always_comb begin
    cols_eff = (grid_cols < brg2d_pkg::COLS_MIN) ? brg2d_pkg::COLS_MIN :
               (grid_cols > brg2d_pkg::COLS_MAX) ? brg2d_pkg::COLS_MAX : grid_cols;
    rows_eff = (grid_rows < brg2d_pkg::ROWS_MIN) ? brg2d_pkg::ROWS_MIN :
               (grid_rows > brg2d_pkg::ROWS_MAX) ? brg2d_pkg::ROWS_MAX : grid_rows;
    last_col = {1'b0, col_count} >= (cols_eff - 7'd1);
    last_row = {1'b0, row_count} >= (rows_eff - 13'd1);
    prow     = row_count - 12'd1;
    edge_now = (prow == '0) || ({1'b0, prow} >= (rows_eff - 13'd1)) ||
               (col_count == '0) || last_col;
  end

  assign s_tready = (state == brg2d_pkg::S_IDLE);
  assign s_acc    = s_tvalid & s_tready;

  // raster counters
  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= '0;
      col_count <= '0;
    end else if (s_acc) begin
      if (last_col) begin
        col_count <= '0;
        row_count <= last_row ? '0 : row_count + 12'd1;
      end else begin
        col_count <= col_count + 6'd1;
      end
    end
  end

  // latched word and its position flags
  always_ff @(posedge clk) begin
    if (s_acc) begin
      in_u     <= s_tdata[SB-1:0];
      in_v     <= s_tdata[2*SB-1:SB];
      pos_r    <= row_count;
      pos_c    <= col_count;
      has_res1 <= (row_count != '0);
      has_res2 <= last_row;
      edge1    <= edge_now;
      done2    <= last_col;
    end
  end

  // line banks: bank = row parity; previous row read at west, center, east
  always_comb begin
    case (state)
      brg2d_pkg::S_RD0: prv_addr = pos_c - 6'd1;
      brg2d_pkg::S_RD1: prv_addr = pos_c;
      default:          prv_addr = pos_c + 6'd1;
    endcase
    rd_addr0 = pos_r[0] ? prv_addr : pos_c;
    rd_addr1 = pos_r[0] ? pos_c : prv_addr;
    prv_rd   = pos_r[0] ? rd_data0 : rd_data1;
    cur_rd   = pos_r[0] ? rd_data1 : rd_data0;
  end

  brg2d_line_bank u_bank0 (
    .clk     (clk),
    .wr_en   ((state == brg2d_pkg::S_RD3) && !pos_r[0]),
    .wr_addr (pos_c),
    .wr_data ({in_v, in_u}),
    .rd_addr (rd_addr0),
    .rd_data (rd_data0)
  );

  brg2d_line_bank u_bank1 (
    .clk     (clk),
    .wr_en   ((state == brg2d_pkg::S_RD3) && pos_r[0]),
    .wr_addr (pos_c),
    .wr_data ({in_v, in_u}),
    .rd_addr (rd_addr1),
    .rd_data (rd_data1)
  );

  // neighborhood capture
  always_ff @(posedge clk) begin
    case (state)
      brg2d_pkg::S_RD1: begin
        st_west  <= prv_rd;
        st_north <= cur_rd;
      end
      brg2d_pkg::S_RD2: st_cen  <= prv_rd;
      brg2d_pkg::S_RD3: st_east <= prv_rd;
      default: ;
    endcase
  end

  // chain entry: u field then v field
  always_comb begin
    chain[0].valid    = (state == brg2d_pkg::S_ISSUE_U) || (state == brg2d_pkg::S_ISSUE_V);
    chain[0].is_v     = (state == brg2d_pkg::S_ISSUE_V);
    chain[0].st.uc    = st_cen[SB-1:0];
    chain[0].st.vc    = st_cen[2*SB-1:SB];
    if (state == brg2d_pkg::S_ISSUE_V) begin
      chain[0].st.cen   = st_cen[2*SB-1:SB];
      chain[0].st.west  = st_west[2*SB-1:SB];
      chain[0].st.east  = st_east[2*SB-1:SB];
      chain[0].st.north = st_north[2*SB-1:SB];
      chain[0].st.south = in_v;
    end else begin
      chain[0].st.cen   = st_cen[SB-1:0];
      chain[0].st.west  = st_west[SB-1:0];
      chain[0].st.east  = st_east[SB-1:0];
      chain[0].st.north = st_north[SB-1:0];
      chain[0].st.south = in_u;
    end
    chain[0].sum = brg2d_pkg::sx64(chain[0].st.cen);
  end

  assign cell_coef[0] = coef_adv_col;
  assign cell_coef[1] = coef_adv_row;
  assign cell_coef[2] = coef_diff_col;
  assign cell_coef[3] = coef_diff_row;

  // chain of term cells
  for (genvar i = 0; i < brg2d_pkg::NUM_CELLS; i++) begin : g_cell
    brg2d_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .kind (brg2d_pkg::term_kind_t'(2'(i))),
      .coef (cell_coef[i]),
      .din  (chain[i]),
      .dout (chain[i+1])
    );
  end

  // saturated results
  always_ff @(posedge clk) begin
    if (chain[brg2d_pkg::NUM_CELLS].valid) begin
      if (chain[brg2d_pkg::NUM_CELLS].is_v) begin
        res_v <= brg2d_pkg::sat32(chain[brg2d_pkg::NUM_CELLS].sum);
      end else begin
        res_u <= brg2d_pkg::sat32(chain[brg2d_pkg::NUM_CELLS].sum);
      end
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= brg2d_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      brg2d_pkg::S_IDLE:    if (s_acc) state_next = brg2d_pkg::S_RD0;
      brg2d_pkg::S_RD0:     state_next = brg2d_pkg::S_RD1;
      brg2d_pkg::S_RD1:     state_next = brg2d_pkg::S_RD2;
      brg2d_pkg::S_RD2:     state_next = brg2d_pkg::S_RD3;
      brg2d_pkg::S_RD3:     state_next = has_res1 ? brg2d_pkg::S_ISSUE_U : brg2d_pkg::S_IDLE;
      brg2d_pkg::S_ISSUE_U: state_next = brg2d_pkg::S_ISSUE_V;
      brg2d_pkg::S_ISSUE_V: state_next = brg2d_pkg::S_WAIT;
      brg2d_pkg::S_WAIT: begin
        if (chain[brg2d_pkg::NUM_CELLS].valid && chain[brg2d_pkg::NUM_CELLS].is_v) begin
          state_next = brg2d_pkg::S_EMIT1;
        end
      end
      brg2d_pkg::S_EMIT1: begin
        if (m_tready) state_next = has_res2 ? brg2d_pkg::S_EMIT2 : brg2d_pkg::S_IDLE;
      end
      brg2d_pkg::S_EMIT2:   if (m_tready) state_next = brg2d_pkg::S_IDLE;
      default:              state_next = brg2d_pkg::S_IDLE;
    endcase
  end

  // result word
  assign emit2    = (state == brg2d_pkg::S_EMIT2);
  assign m_tvalid = (state == brg2d_pkg::S_EMIT1) || emit2;
  assign m_tlast  = emit2 || !has_res2;
  assign m_tuser  = emit2 && done2;
  assign m_tdata  = {6'b0,
                     pos_c,
                     emit2 ? pos_r : (pos_r - 12'd1),
                     (emit2 || edge1) ? boundary_value : res_v,
                     (emit2 || edge1) ? boundary_value : res_u};

  // checks
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !s_tready) else $error("input taken while a result is pending");

  a_chain_in_wait: assert property (@(posedge clk) disable iff (rst)
    chain[brg2d_pkg::NUM_CELLS].valid |-> (state == brg2d_pkg::S_WAIT))
    else $error("chain output outside wait state");

  a_frame_is_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> m_tlast) else $error("frame end not last of run");

  a_second_follows: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && !m_tlast) |=> (m_tvalid && m_tlast))
    else $error("second result missing");

endmodule

[verif/tb_burgers_2d_stencil_step.sv]
// Self-checking testbench for burgers_2d_stencil_step: drives grids in raster order, predicts
// every result point with its own fixed-point stencil model or a pinned value, and checks the result stream.
// Depends on brg2d_pkg and the burgers_2d_stencil_step RTL.
module tb_burgers_2d_stencil_step;

  localparam int WDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 120;

  typedef struct {
    logic [31:0] u;
    logic [31:0] v;
    logic [11:0] row;
    logic [5:0]  col;
    logic        done;
    logic        last;
  } grid_point_t;

  // one directed word; when pin is set the first result's u/v are fixed
  typedef struct {
    logic [31:0] u;
    logic [31:0] v;
    logic        pin;
    logic [31:0] pu;
    logic [31:0] pv;
  } dir_word_t;

  typedef enum int {
    IDLE_SEND_LIGHT,
    IDLE_RECV_LIGHT,
    IDLE_NONE
  } idle_mode_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [87:0] m_tdata;
  logic        m_tlast;
  logic        m_tuser;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  burgers_2d_stencil_step dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tlast(m_tlast), .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor copy of the registers and line banks
  logic [31:0] k_adv_col, k_adv_row, k_dif_col, k_dif_row, bnd_reg;
  logic [6:0]  cols_reg;
  logic [12:0] rows_reg;
  logic [31:0] u_bank [2*brg2d_pkg::MAX_COLS];
  logic [31:0] v_bank [2*brg2d_pkg::MAX_COLS];
  int unsigned row_pos, col_pos;

  grid_point_t pending_points[$];
  int          n_fail = 0;
  int          n_words_in = 0;
  int          n_points_out = 0;
  int          n_grids = 0;
  idle_mode_t  idle_mode = IDLE_NONE;
  int          hold_cycles = 0;
  int          quiet_cycles = 0;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    n_fail++;
    $display("MISMATCH %s: got %h want %h (point %0d)", what, got, want, n_points_out);
  endtask

  // round(a*b*k / 2^sh) to nearest, ties up, capped at 2^60
  function automatic longint unsigned scaled_term(input longint unsigned a,
      input longint unsigned b, input logic [31:0] k, input int sh);
    logic [127:0] p;
    p = 128'(a) * 128'(b) * 128'(k);
    p = (p + (128'(1) << (sh - 1))) >> sh;
    if (p > (128'(1) << 60)) p = 128'(1) << 60;
    return p[63:0];
  endfunction

  function automatic longint unsigned absval(input longint x);
    return (x < 0) ? longint'(-x) : longint'(x);
  endfunction

  function automatic longint advect(input longint vel, input longint d, input logic [31:0] k);
    longint m;
    m = longint'(scaled_term(absval(vel), absval(d), k, brg2d_pkg::ADV_SHIFT));
    return ((vel < 0) != (d < 0)) ? -m : m;
  endfunction

  function automatic longint diffuse(input longint lap, input logic [31:0] k);
    longint m;
    m = longint'(scaled_term(absval(lap), 1, k, brg2d_pkg::DIF_SHIFT));
    return (lap < 0) ? -m : m;
  endfunction

  function automatic logic [31:0] clip32(input longint x);
    if (x > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (x < -64'sd2147483648) return 32'h8000_0000;
    return x[31:0];
  endfunction

  function automatic logic [31:0] burgers_point_update(input logic [31:0] c, w, e, n, s,
      uc, vc);
    longint cc, acc;
    cc = longint'($signed(c));
    acc = cc;
    acc -= advect(longint'($signed(uc)), cc - longint'($signed(w)), k_adv_col);
    acc -= advect(longint'($signed(vc)), cc - longint'($signed(n)), k_adv_row);
    acc += diffuse(longint'($signed(e)) - 2 * cc + longint'($signed(w)), k_dif_col);
    acc += diffuse(longint'($signed(s)) - 2 * cc + longint'($signed(n)), k_dif_row);
    return clip32(acc);
  endfunction

  // advance the grid model by one accepted word, queue the points it yields
  task automatic predict_grid_word(input logic [31:0] su, input logic [31:0] sv,
                                   input logic pin, input logic [31:0] pu,
                                   input logic [31:0] pv);
    int unsigned cols, rows, r, c, cur, prv;
    grid_point_t pt;
    logic last_col, last_row;
    cols = (cols_reg < 3) ? 3 :
           ((cols_reg > brg2d_pkg::MAX_COLS) ? brg2d_pkg::MAX_COLS : cols_reg);
    rows = (rows_reg < 3) ? 3 : ((rows_reg > 4096) ? 4096 : rows_reg);
    r = row_pos;
    c = col_pos % brg2d_pkg::MAX_COLS;
    cur = (r & 1) * brg2d_pkg::MAX_COLS;
    prv = ((r & 1) ^ 1) * brg2d_pkg::MAX_COLS;
    last_col = (c >= cols - 1);
    last_row = (r >= rows - 1);
    if (r >= 1) begin
      pt.row = 12'(r - 1);
      pt.col = 6'(c);
      pt.done = 1'b0;
      pt.last = !last_row;
      if (r - 1 == 0 || r - 1 >= rows - 1 || c == 0 || last_col) begin
        pt.u = bnd_reg;
        pt.v = bnd_reg;
      end else begin
        pt.u = burgers_point_update(u_bank[prv+c], u_bank[prv+c-1], u_bank[prv+c+1],
                                    u_bank[cur+c], su, u_bank[prv+c], v_bank[prv+c]);
        pt.v = burgers_point_update(v_bank[prv+c], v_bank[prv+c-1], v_bank[prv+c+1],
                                    v_bank[cur+c], sv, u_bank[prv+c], v_bank[prv+c]);
      end
      if (pin) begin
        pt.u = pu;
        pt.v = pv;
      end
      pending_points.push_back(pt);
    end
    u_bank[cur+c] = su;
    v_bank[cur+c] = sv;
    if (last_row) begin
      pt.u = bnd_reg;
      pt.v = bnd_reg;
      pt.row = 12'(r);
      pt.col = 6'(c);
      pt.done = last_col;
      pt.last = 1'b1;
      pending_points.push_back(pt);
    end
    if (last_col) begin
      col_pos = 0;
      row_pos = last_row ? 0 : r + 1;
      if (last_row) n_grids++;
    end else begin
      col_pos = c + 1;
    end
  endtask

  // offer one word, wait for acceptance, then predict
  task automatic send_word(input logic [31:0] su, input logic [31:0] sv,
                           input logic pin = 1'b0, input logic [31:0] pu = '0,
                           input logic [31:0] pv = '0);
    if (idle_mode != IDLE_NONE &&
        $urandom_range(99) < ((idle_mode == IDLE_SEND_LIGHT) ? 8 : 56)) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {sv, su};
    do @(posedge clk); while (!s_tready);
    n_words_in++;
    predict_grid_word(su, sv, pin, pu, pv);
  endtask

  // APB write: setup then access cycle
  task automatic write_reg(input brg2d_pkg::cfg_reg_t idx, input logic [31:0] val);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= 5'(4 * idx);
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      brg2d_pkg::REG_ADV_COL:   k_adv_col = val;
      brg2d_pkg::REG_ADV_ROW:   k_adv_row = val;
      brg2d_pkg::REG_DIF_COL:   k_dif_col = val;
      brg2d_pkg::REG_DIF_ROW:   k_dif_row = val;
      brg2d_pkg::REG_BOUNDARY:  bnd_reg = val;
      brg2d_pkg::REG_GRID_COLS: cols_reg = val[6:0];
      brg2d_pkg::REG_GRID_ROWS: rows_reg = val[12:0];
      default: ;
    endcase
  endtask

  // block drained and past its pipeline before any register write
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_all(input logic [31:0] kac, kar, kdc, kdr, bnd, cols, rows);
    write_reg(brg2d_pkg::REG_ADV_COL, kac);
    write_reg(brg2d_pkg::REG_ADV_ROW, kar);
    write_reg(brg2d_pkg::REG_DIF_COL, kdc);
    write_reg(brg2d_pkg::REG_DIF_ROW, kdr);
    write_reg(brg2d_pkg::REG_BOUNDARY, bnd);
    write_reg(brg2d_pkg::REG_GRID_COLS, cols);
    write_reg(brg2d_pkg::REG_GRID_ROWS, rows);
  endtask

  function automatic logic [31:0] rand_velocity();
    case ($urandom_range(3))
      0: return $urandom();
      1: return 32'($urandom_range(0, 32'h0400_0000)) - 32'h0200_0000;
      default: return 32'($urandom_range(0, 32'h0200_0000)) - 32'h0100_0000;
    endcase
  endfunction

  // receiver ready, with an optional long hold-off
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      m_tready <= 1'b0;
    end else if (idle_mode == IDLE_RECV_LIGHT) begin
      m_tready <= ($urandom_range(99) >= 8);
    end else if (idle_mode == IDLE_SEND_LIGHT) begin
      m_tready <= ($urandom_range(99) >= 56);
    end else begin
      m_tready <= 1'b1;
    end
  end

  // result checker
  always @(posedge clk) begin
    grid_point_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_points.size() == 0) begin
        n_fail++;
        $display("MISMATCH unexpected result word %h", m_tdata);
      end else begin
        want = pending_points.pop_front();
        if (m_tdata[31:0] !== want.u) report_mismatch("u_out", m_tdata[31:0], want.u);
        if (m_tdata[63:32] !== want.v) report_mismatch("v_out", m_tdata[63:32], want.v);
        if (m_tdata[75:64] !== want.row)
          report_mismatch("out_row", 32'(m_tdata[75:64]), 32'(want.row));
        if (m_tdata[81:76] !== want.col)
          report_mismatch("out_col", 32'(m_tdata[81:76]), 32'(want.col));
        if (m_tuser !== want.done)
          report_mismatch("frame_done", 32'(m_tuser), 32'(want.done));
        if (m_tlast !== want.last)
          report_mismatch("last_of_run", 32'(m_tlast), 32'(want.last));
      end
      n_points_out++;
    end
  end

  // watchdog on stalled traffic
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WDOG_LIMIT) begin
      $display("Timeout: no traffic for %0d cycles, %0d points outstanding", WDOG_LIMIT,
               pending_points.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    dir_word_t dir_tab[18];
    int cols, rows;
    // two 3x3 grids: edges carry the boundary, centre saturates
    dir_tab = '{
      '{32'h0000_0000, 32'h0000_0000, 1'b0, 0, 0},
      '{32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 0, 0},
      '{32'hFFFF_FFFF, 32'h0000_0001, 1'b0, 0, 0},
      '{32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 32'h8000_0000, 32'h8000_0000},
      '{32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 32'h8000_0000, 32'h8000_0000},
      '{32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 32'h8000_0000, 32'h8000_0000},
      '{32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 32'h8000_0000, 32'h8000_0000},
      '{32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 0, 0},
      '{32'h0100_0000, 32'h0100_0000, 1'b1, 32'h8000_0000, 32'h8000_0000},
      '{32'h0100_0000, 32'hFF00_0000, 1'b0, 0, 0},
      '{32'h0100_0000, 32'hFF00_0000, 1'b0, 0, 0},
      '{32'h0100_0000, 32'hFF00_0000, 1'b0, 0, 0},
      '{32'hFF00_0000, 32'h0100_0000, 1'b1, 32'h8000_0000, 32'h8000_0000},
      '{32'h0200_0000, 32'h0000_0000, 1'b0, 0, 0},
      '{32'hFF00_0000, 32'h0100_0000, 1'b1, 32'h8000_0000, 32'h8000_0000},
      '{32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 32'h8000_0000, 32'h8000_0000},
      '{32'h0000_0000, 32'h8000_0000, 1'b0, 0, 0},
      '{32'h8000_0000, 32'hFFFF_FFFF, 1'b1, 32'h8000_0000, 32'h8000_0000}
    };
    // predictor registers start at their reset values
    k_adv_col = 32'd4831838;
    k_adv_row = 32'd4831838;
    k_dif_col = 32'd966368;
    k_dif_row = 32'd966368;
    bnd_reg = 32'h0100_0000;
    cols_reg = 7'd41;
    rows_reg = 13'd41;
    row_pos = 0;
    col_pos = 0;
    foreach (u_bank[i]) begin
      u_bank[i] = '0;
      v_bank[i] = '0;
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    // directed: sizes below range clamp to 3x3, full-scale coefficients
    write_all(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
              32'h8000_0000, 32'd0, 32'd1);
    foreach (dir_tab[i])
      send_word(dir_tab[i].u, dir_tab[i].v, dir_tab[i].pin, dir_tab[i].pu, dir_tab[i].pv);

    // random phases, one whole grid each, three idling modes
    for (int ph = 0; ph < 9; ph++) begin
      wait_idle();
      idle_mode = (ph < 3) ? IDLE_SEND_LIGHT : ((ph < 6) ? IDLE_RECV_LIGHT : IDLE_NONE);
      cols = $urandom_range(3, 12);
      rows = $urandom_range(3, 7);
      if (ph == 1) begin
        cols = 127;  // clamps to the widest row
        rows = 3;
      end
      if (ph == 4) begin
        cols = 64;
        rows = 4;
      end
      case (ph)
        0: write_all(32'd4831838, 32'd4831838, 32'd966368, 32'd966368,
                     32'h7FFF_FFFF, cols, rows);
        3: write_all(32'd0, 32'd0, 32'd0, 32'd0, 32'h0000_0000, cols, rows);
        default: write_all($urandom_range(0, 32'h2000_0000), $urandom_range(0, 32'h2000_0000),
                           $urandom_range(0, 32'h1000_0000), $urandom(), $urandom(),
                           cols, rows);
      endcase
      if (ph == 2) hold_cycles = 600;  // long receiver stall backs the block up
      for (int i = 0; i < ((cols > 64) ? 64 : cols) * rows; i++)
        send_word(rand_velocity(), rand_velocity());
    end

    s_tvalid <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d grid words over %0d grids, checked %0d result points.",
             n_words_in, n_grids, n_points_out);
    $display("Covered clamped sizes, saturation, boundary rows and three stall patterns.");
    if (n_fail == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
